>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define SRTF_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds while reset is applied.
`define SRTF_CHECK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> sv/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_TIME_BITS     = 24;

    localparam int COUNT_W  = 5;
    localparam int SLOT_F_W = 4;
    localparam int ID_W     = 8;
    localparam int SHORT_W  = 16;
    localparam int OUT_T_W  = 24;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // saturating count of unfinished slots in use
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_MANY = 2'd2;

    typedef struct packed {
        logic               en;
        logic [SLOT_F_W-1:0] slot;
        logic [ID_W-1:0]    id;
        logic [SHORT_W-1:0] arrival;
        logic [SHORT_W-1:0] burst;
    } load_t;

    typedef struct packed {
        logic               valid;
        logic [1:0]         pend;
        logic               started;
        logic [ID_W-1:0]    id;
        logic [SHORT_W-1:0] arrival;
        logic [SHORT_W-1:0] burst;
        logic [SHORT_W-1:0] remaining;
    } cand_t;

    typedef struct packed {
        logic                idle;
        logic [SLOT_F_W-1:0] run_slot;
        logic [ID_W-1:0]     run_id;
        logic [OUT_T_W-1:0]  tick_start;
        logic                new_segment;
        logic                finished;
        logic [OUT_T_W-1:0]  completion_time;
        logic [OUT_T_W-1:0]  turnaround;
        logic [OUT_T_W-1:0]  waiting;
        logic [OUT_T_W-1:0]  response;
        logic                all_done;
    } result_t;

endpackage

>>> sv/srtf_if.sv
`timescale 1ns / 1ps

interface srtf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [srtf_pkg::SLOT_F_W-1:0] slot;
    logic [srtf_pkg::ID_W-1:0]     process_id;
    logic [srtf_pkg::SHORT_W-1:0]  arrival;
    logic [srtf_pkg::SHORT_W-1:0]  burst;

    modport source (output valid, kind, slot, process_id, arrival, burst, input ready);
    modport sink   (input valid, kind, slot, process_id, arrival, burst, output ready);
endinterface

interface srtf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          idle;
    logic [srtf_pkg::SLOT_F_W-1:0] run_slot;
    logic [srtf_pkg::ID_W-1:0]     run_id;
    logic [srtf_pkg::OUT_T_W-1:0]  tick_start;
    logic                          new_segment;
    logic                          finished;
    logic [srtf_pkg::OUT_T_W-1:0]  completion_time;
    logic [srtf_pkg::OUT_T_W-1:0]  turnaround;
    logic [srtf_pkg::OUT_T_W-1:0]  waiting;
    logic [srtf_pkg::OUT_T_W-1:0]  response;
    logic                          all_done;

    modport source (output valid, idle, run_slot, run_id, tick_start, new_segment, finished,
                    completion_time, turnaround, waiting, response, all_done,
                    input ready);
    modport sink   (input valid, idle, run_slot, run_id, tick_start, new_segment, finished,
                    completion_time, turnaround, waiting, response, all_done,
                    output ready);
endinterface

>>> sv/srtf_process_scheduler.sv
`timescale 1ns / 1ps

// Shortest-remaining-time-first scheduler over MAX_PROCESSES slots.
// cfg_we/cfg_data write process_count (slots 0..count-1 in use); write
// only while no item is in flight.
// item channel (valid/ready): kind 0 loads one slot, kind 1 is one tick.
// result channel (valid/ready): exactly one result beat per item beat.
// Each slot lives in one cell of a chain; the best candidate so far
// ripples one cell per clock; items are handled one at a time.
// The result sits in an output register, so a new item may be taken
// while it waits; if the receiver still stalls when the next result is
// ready, the block holds it and takes no further item.
// Reset clears time, run history, started and done marks and the count;
// slot contents are undefined until loaded. No clearing pass is needed.
module srtf_process_scheduler #(
    parameter int MAX_PROCESSES = srtf_pkg::DEF_MAX_PROCESSES,
    parameter int TIME_BITS     = srtf_pkg::DEF_TIME_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [srtf_pkg::COUNT_W-1:0] cfg_data,
    srtf_in_if.sink                      item,
    srtf_out_if.source                   result
);

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CW     = (TIME_BITS > srtf_pkg::SHORT_W) ? TIME_BITS : srtf_pkg::SHORT_W;
    localparam int OW     = (CW > srtf_pkg::OUT_T_W) ? CW : srtf_pkg::OUT_T_W;
    localparam int SW     = (SLOT_W > srtf_pkg::SLOT_F_W) ? SLOT_W : srtf_pkg::SLOT_F_W;
    localparam logic [SLOT_W-1:0]    LAST_CNT = SLOT_W'(MAX_PROCESSES - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [SLOT_W-1:0]              cnt_reg;
    logic                           kind_reg;
    logic [srtf_pkg::COUNT_W-1:0]   count_reg;
    logic [TIME_BITS-1:0]           time_reg;
    logic [srtf_pkg::ID_W-1:0]      last_id_reg;
    logic                           last_valid_reg;
    logic [TIME_BITS-1:0]           last_end_reg;
    logic                           out_valid_reg;
    srtf_pkg::result_t              res_reg;
    srtf_pkg::result_t              res_next;

    srtf_pkg::cand_t                cand_chain [0:MAX_PROCESSES];
    logic [SLOT_W-1:0]              slot_chain [0:MAX_PROCESSES];
    logic [TIME_BITS-1:0]           resp_chain [0:MAX_PROCESSES];

    srtf_pkg::load_t                load_bus;
    srtf_pkg::cand_t                tail;
    logic                           in_acc;
    logic                           out_free;
    logic                           pick;
    logic                           fin;
    logic                           apply_en;
    logic [TIME_BITS-1:0]           end_time;
    logic [CW-1:0]                  arr_c;
    logic [CW-1:0]                  burst_c;
    logic [CW-1:0]                  start_c;
    logic [CW-1:0]                  end_c;
    logic [CW-1:0]                  tat_c;
    logic [CW-1:0]                  wait_c;
    logic [CW-1:0]                  resp_c;
    logic [OW-1:0]                  start_w;
    logic [OW-1:0]                  end_w;
    logic [OW-1:0]                  tat_w;
    logic [OW-1:0]                  wait_w;
    logic [OW-1:0]                  resp_w;
    logic [SW-1:0]                  slot_w;

    assign item.ready = (state_reg == ST_IDLE);
    assign in_acc     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    assign load_bus.en      = in_acc && (item.kind == srtf_pkg::KIND_LOAD);
    assign load_bus.slot    = item.slot;
    assign load_bus.id      = item.process_id;
    assign load_bus.arrival = item.arrival;
    assign load_bus.burst   = item.burst;

    assign cand_chain[0] = '0;
    assign slot_chain[0] = '0;
    assign resp_chain[0] = '0;

    for (genvar i = 0; i < MAX_PROCESSES; i++)
    begin : g_cell
        srtf_cell #(
            .MAX_PROCESSES (MAX_PROCESSES),
            .TIME_BITS     (TIME_BITS),
            .IDX           (i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .process_count (count_reg),
            .cur_time      (time_reg),
            .load          (load_bus),
            .apply_en      (apply_en),
            .apply_slot    (slot_chain[MAX_PROCESSES]),
            .cand_in       (cand_chain[i]),
            .slot_in       (slot_chain[i]),
            .resp_in       (resp_chain[i]),
            .cand_out      (cand_chain[i+1]),
            .slot_out      (slot_chain[i+1]),
            .resp_out      (resp_chain[i+1])
        );
    end

    assign tail     = cand_chain[MAX_PROCESSES];
    assign pick     = (kind_reg == srtf_pkg::KIND_TICK) && tail.valid;
    assign fin      = tail.remaining == srtf_pkg::SHORT_W'(1);
    assign apply_en = (state_reg == ST_FINISH) && out_free && pick;
    assign end_time = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_BITS'(1);

    assign arr_c   = CW'(tail.arrival);
    assign burst_c = CW'(tail.burst);
    assign start_c = CW'(time_reg);
    assign end_c   = CW'(end_time);
    assign tat_c   = end_c - arr_c;
    assign wait_c  = (tat_c >= burst_c) ? tat_c - burst_c : '0;
    assign resp_c  = tail.started ? CW'(resp_chain[MAX_PROCESSES]) : start_c - arr_c;

    assign start_w = OW'(time_reg);
    assign end_w   = OW'(end_time);
    assign tat_w   = OW'(TIME_BITS'(tat_c));
    assign wait_w  = OW'(TIME_BITS'(wait_c));
    assign resp_w  = OW'(TIME_BITS'(resp_c));
    assign slot_w  = SW'(slot_chain[MAX_PROCESSES]);

    always_comb
    begin
        res_next      = '0;
        res_next.idle = 1'b1;
        if (kind_reg == srtf_pkg::KIND_TICK)
        begin
            res_next.tick_start = start_w[srtf_pkg::OUT_T_W-1:0];
        end
        if (pick)
        begin
            res_next.idle        = 1'b0;
            res_next.run_slot    = slot_w[srtf_pkg::SLOT_F_W-1:0];
            res_next.run_id      = tail.id;
            res_next.new_segment = !(last_valid_reg && (last_id_reg == tail.id) &&
                                     (last_end_reg == time_reg));
            if (fin)
            begin
                res_next.finished        = 1'b1;
                res_next.completion_time = end_w[srtf_pkg::OUT_T_W-1:0];
                res_next.turnaround      = tat_w[srtf_pkg::OUT_T_W-1:0];
                res_next.waiting         = wait_w[srtf_pkg::OUT_T_W-1:0];
                res_next.response        = resp_w[srtf_pkg::OUT_T_W-1:0];
            end
        end
        res_next.all_done = (tail.pend == srtf_pkg::PEND_NONE) ||
                            ((tail.pend == srtf_pkg::PEND_ONE) && pick && fin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            kind_reg       <= srtf_pkg::KIND_LOAD;
            count_reg      <= '0;
            time_reg       <= '0;
            last_id_reg    <= '0;
            last_valid_reg <= 1'b0;
            last_end_reg   <= '0;
            out_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
            if (out_valid_reg && result.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        kind_reg  <= item.kind;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + SLOT_W'(1);
                    if (cnt_reg == LAST_CNT)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        res_reg       <= res_next;
                        if (kind_reg == srtf_pkg::KIND_TICK)
                        begin
                            time_reg <= end_time;
                        end
                        if (pick)
                        begin
                            last_valid_reg <= 1'b1;
                            last_id_reg    <= tail.id;
                            last_end_reg   <= end_time;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.idle            = res_reg.idle;
    assign result.run_slot        = res_reg.run_slot;
    assign result.run_id          = res_reg.run_id;
    assign result.tick_start      = res_reg.tick_start;
    assign result.new_segment     = res_reg.new_segment;
    assign result.finished        = res_reg.finished;
    assign result.completion_time = res_reg.completion_time;
    assign result.turnaround      = res_reg.turnaround;
    assign result.waiting         = res_reg.waiting;
    assign result.response        = res_reg.response;
    assign result.all_done        = res_reg.all_done;

endmodule

>>> sv/srtf_cell.sv
`timescale 1ns / 1ps

module srtf_cell #(
    parameter int MAX_PROCESSES = srtf_pkg::DEF_MAX_PROCESSES,
    parameter int TIME_BITS     = srtf_pkg::DEF_TIME_BITS,
    parameter int IDX           = 0,
    localparam int SLOT_W       = $clog2(MAX_PROCESSES)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [srtf_pkg::COUNT_W-1:0] process_count,
    input  logic [TIME_BITS-1:0]         cur_time,
    input  srtf_pkg::load_t              load,
    input  logic                         apply_en,
    input  logic [SLOT_W-1:0]            apply_slot,
    input  srtf_pkg::cand_t              cand_in,
    input  logic [SLOT_W-1:0]            slot_in,
    input  logic [TIME_BITS-1:0]         resp_in,
    output srtf_pkg::cand_t              cand_out,
    output logic [SLOT_W-1:0]            slot_out,
    output logic [TIME_BITS-1:0]         resp_out
);

    localparam int CW = (TIME_BITS > srtf_pkg::SHORT_W) ? TIME_BITS : srtf_pkg::SHORT_W;
    localparam logic [8:0]        IDX9    = 9'(IDX);
    localparam logic [SLOT_W-1:0] IDX_SLT = SLOT_W'(IDX);

    logic [srtf_pkg::ID_W-1:0]    id_reg;
    logic [srtf_pkg::SHORT_W-1:0] arr_reg;
    logic [srtf_pkg::SHORT_W-1:0] burst_reg;
    logic [srtf_pkg::SHORT_W-1:0] rem_reg;
    logic [TIME_BITS-1:0]         resp_reg;
    logic                         started_reg;
    logic                         done_reg;

    srtf_pkg::cand_t              cand_reg;
    srtf_pkg::cand_t              cand_next;
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            slot_next;
    logic [TIME_BITS-1:0]         tok_resp_reg;
    logic [TIME_BITS-1:0]         tok_resp_next;

    logic                         in_use;
    logic                         load_hit;
    logic                         apply_hit;
    logic                         eligible;
    logic                         better;
    logic [CW-1:0]                arr_c;
    logic [CW-1:0]                start_c;
    logic [1:0]                   pend_next;

    assign arr_c     = CW'(arr_reg);
    assign start_c   = CW'(cur_time);
    assign in_use    = IDX9 < {4'b0, process_count};
    assign load_hit  = load.en && ({5'b0, load.slot} == IDX9);
    assign apply_hit = apply_en && (apply_slot == IDX_SLT);

    assign eligible = in_use && !done_reg && (rem_reg != '0) && (arr_c <= start_c);
    assign better   = !cand_in.valid || (rem_reg < cand_in.remaining) ||
                      ((rem_reg == cand_in.remaining) && (arr_reg < cand_in.arrival));

    always_comb
    begin
        pend_next = cand_in.pend;
        if (in_use && !done_reg)
        begin
            pend_next = (cand_in.pend == srtf_pkg::PEND_NONE) ? srtf_pkg::PEND_ONE
                                                               : srtf_pkg::PEND_MANY;
        end

        cand_next      = cand_in;
        slot_next      = slot_in;
        tok_resp_next  = resp_in;
        if (eligible && better)
        begin
            cand_next.valid     = 1'b1;
            cand_next.started   = started_reg;
            cand_next.id        = id_reg;
            cand_next.arrival   = arr_reg;
            cand_next.burst     = burst_reg;
            cand_next.remaining = rem_reg;
            slot_next           = IDX_SLT;
            tok_resp_next       = resp_reg;
        end
        cand_next.pend = pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            cand_reg    <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (load_hit)
            begin
                started_reg <= 1'b0;
                done_reg    <= 1'b0;
            end
            else if (apply_hit)
            begin
                started_reg <= 1'b1;
                if (rem_reg == srtf_pkg::SHORT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        tok_resp_reg <= tok_resp_next;
        if (load_hit)
        begin
            id_reg    <= load.id;
            arr_reg   <= load.arrival;
            burst_reg <= load.burst;
            rem_reg   <= load.burst;
            resp_reg  <= '0;
        end
        else if (apply_hit)
        begin
            rem_reg <= rem_reg - srtf_pkg::SHORT_W'(1);
            if (!started_reg)
            begin
                resp_reg <= TIME_BITS'(start_c - arr_c);
            end
        end
    end

    assign cand_out = cand_reg;
    assign slot_out = slot_reg;
    assign resp_out = tok_resp_reg;

endmodule

>>> sv/srtf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srtf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // beats taken in but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else if (in_acc && !out_acc && (pend_reg != 2'd3))
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (out_acc && !in_acc && (pend_reg != 2'd0))
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    `SRTF_CHECK(a_ready_drops, clk, rst_n, in_acc |=> !in_ready, "item taken back to back")
    `SRTF_CHECK(a_out_holds, clk, rst_n, out_valid && !out_ready |=> out_valid, "result beat dropped")
    `SRTF_CHECK(a_no_orphan, clk, rst_n, out_acc |-> (pend_reg != 2'd0), "result without item")
    `SRTF_CHECK_ALWAYS(a_one_ahead, clk, in_acc |-> !pend_reg[1], "too many items in flight")

endmodule

bind srtf_process_scheduler srtf_checker u_srtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready)
);
